// ----- rtl/wtg_pkg.sv -----
// Package for the windowed trigger gate: beat payload types and register codes.
// No dependencies; wtg_gate, the top level and the bench import it.

package wtg_pkg;

	// Width of the configuration register index.
	localparam int CFG_INDEX_BITS = 2;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_MIN_WAIT   = 2'd0,
		REG_MAX_WAIT   = 2'd1,
		REG_PASS_COUNT = 2'd2
	} wtg_reg_t;

	// One input beat: one sample tick with its two triggers.
	typedef struct packed {
		logic pass_trigger;
		logic arm_trigger;
	} wtg_sample_t;

	// One result beat.
	typedef struct packed {
		logic trigger_out;
		logic waiting;
	} wtg_result_t;

endpackage

// ----- rtl/wtg_stream_if.sv -----
// Valid/ready stream interface used for the sample and result channels.
// The payload type is a parameter; the block's types come from wtg_pkg.

interface wtg_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/wtg_gate.sv -----
// Gate state for the windowed trigger gate: configuration registers, wait and
// pass counters, and the per-tick next-state logic. Depends on wtg_pkg.

module wtg_gate #(
	parameter int WAIT_BITS     = 24,
	parameter int COUNT_BITS    = 16,
	parameter int CFG_DATA_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step,
	input  wtg_pkg::wtg_sample_t                sample,
	output wtg_pkg::wtg_result_t                result,
	input  logic                                cfg_wr_en,
	input  logic [wtg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0]            cfg_data
);
	import wtg_pkg::*;

	logic [WAIT_BITS-1:0]  min_wait_q, max_wait_q;
	logic [COUNT_BITS-1:0] pass_count_q;
	logic                  wait_q;
	logic [WAIT_BITS-1:0]  min_left_q, max_left_q;
	logic [COUNT_BITS-1:0] passes_left_q;

	logic [WAIT_BITS-1:0]  min_wait_d, max_wait_d;
	logic [COUNT_BITS-1:0] pass_count_d;
	logic                  cfg_hit;

	logic                  wait_d;
	logic [WAIT_BITS-1:0]  min_left_d, max_left_d;
	logic [COUNT_BITS-1:0] passes_left_d;
	logic                  trig_d;

	// Register write decode. An unknown index changes nothing.
	always_comb begin
		min_wait_d   = min_wait_q;
		max_wait_d   = max_wait_q;
		pass_count_d = pass_count_q;
		cfg_hit      = 1'b0;
		unique case (wtg_reg_t'(cfg_index))
			REG_MIN_WAIT: begin
				min_wait_d = cfg_data[WAIT_BITS-1:0];
				cfg_hit    = cfg_wr_en;
			end
			REG_MAX_WAIT: begin
				max_wait_d = cfg_data[WAIT_BITS-1:0];
				cfg_hit    = cfg_wr_en;
			end
			REG_PASS_COUNT: begin
				pass_count_d = cfg_data[COUNT_BITS-1:0];
				cfg_hit      = cfg_wr_en;
			end
			default: begin
				cfg_hit = 1'b0;
			end
		endcase
	end

	// One tick: the waiting phase first, then the passing phase on the updated flag.
	always_comb begin
		wait_d        = wait_q;
		min_left_d    = min_left_q;
		max_left_d    = max_left_q;
		passes_left_d = passes_left_q;
		trig_d        = 1'b0;

		if (wait_q) begin
			if (min_left_q == '0) begin
				if (sample.arm_trigger || (max_left_q == '0 && max_wait_q != '0)) begin
					wait_d        = 1'b0;
					passes_left_d = pass_count_q;
				end
			end else begin
				min_left_d = min_left_q - WAIT_BITS'(1);
			end
			// The timeout counter stops at zero.
			if (max_wait_q != '0 && max_left_q != '0) begin
				max_left_d = max_left_q - WAIT_BITS'(1);
			end
		end

		if (!wait_d && sample.pass_trigger) begin
			trig_d        = 1'b1;
			passes_left_d = passes_left_d - COUNT_BITS'(1);
			if (passes_left_d == '0) begin
				min_left_d = min_wait_q;
				max_left_d = max_wait_q;
				wait_d     = 1'b1;
			end
		end
	end

	assign result.trigger_out = trig_d;
	assign result.waiting     = wait_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_wait_q    <= '0;
			max_wait_q    <= '0;
			pass_count_q  <= COUNT_BITS'(1);
			wait_q        <= 1'b1;
			min_left_q    <= '0;
			max_left_q    <= '0;
			passes_left_q <= '0;
		end else if (cfg_hit) begin
			// A register write reloads both wait counters and restarts waiting.
			min_wait_q   <= min_wait_d;
			max_wait_q   <= max_wait_d;
			pass_count_q <= pass_count_d;
			min_left_q   <= min_wait_d;
			max_left_q   <= max_wait_d;
			wait_q       <= 1'b1;
		end else if (step) begin
			wait_q        <= wait_d;
			min_left_q    <= min_left_d;
			max_left_q    <= max_left_d;
			passes_left_q <= passes_left_d;
		end
	end

endmodule

// ----- rtl/windowed_trigger_gate_core.sv -----
// Top level of the windowed trigger gate: stream handshake, result register
// with skid entry, and the configuration port. Depends on wtg_pkg,
// wtg_stream_if and wtg_gate.
//
//   Channel   Direction  Payload                         Handshake
//   samples   in         pass_trigger, arm_trigger       valid / ready
//   results   out        trigger_out, waiting            valid / ready
//   cfg       in         cfg_index, cfg_data             cfg_wr_en, no wait
//
// Each sample beat is worked in the cycle it is accepted: the gate state
// updates at that edge and the result lands in the result register or the
// skid entry, and one beat is taken every cycle while samples.ready is high.
// A second result entry absorbs one beat while the result register is
// stalled; samples.ready drops only when both entries are full.
// arst_n clears the configuration (min and max wait 0, pass count 1), puts
// the gate in waiting, and empties both result entries.

module windowed_trigger_gate_core #(
	parameter int WAIT_BITS  = 24,
	parameter int COUNT_BITS = 16,
	localparam int CFG_DATA_BITS = (WAIT_BITS > COUNT_BITS) ? WAIT_BITS : COUNT_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	wtg_stream_if.sink                         samples,
	wtg_stream_if.source                       results,
	input  logic                               cfg_wr_en,
	input  logic [wtg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]           cfg_data
);
	import wtg_pkg::*;

	logic        in_fire;
	logic        out_fire;
	wtg_result_t step_result;

	// Result register (what the results channel shows) and the skid entry.
	logic        main_valid_q;
	wtg_result_t main_q;
	logic        skid_valid_q;
	wtg_result_t skid_q;

	// The skid entry is only ever full while the result register is full,
	// so an empty skid entry means there is room for one more beat.
	assign samples.ready = !skid_valid_q;
	assign in_fire       = samples.valid && samples.ready;
	assign out_fire      = main_valid_q && results.ready;

	assign results.valid = main_valid_q;
	assign results.data  = main_q;

	wtg_gate #(
		.WAIT_BITS     (WAIT_BITS),
		.COUNT_BITS    (COUNT_BITS),
		.CFG_DATA_BITS (CFG_DATA_BITS)
	) u_gate (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (in_fire),
		.sample    (samples.data),
		.result    (step_result),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Valid flags of the two result entries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			// No beat is taken in; the skid entry moves up when the front drains.
			if (out_fire) begin
				skid_valid_q <= 1'b0;
			end
		end else if (in_fire) begin
			if (main_valid_q && !out_fire) begin
				skid_valid_q <= 1'b1;
			end
			main_valid_q <= 1'b1;
		end else if (out_fire) begin
			main_valid_q <= 1'b0;
		end
	end

	// Result payloads.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				main_q <= skid_q;
			end
		end else if (in_fire) begin
			if (main_valid_q && !out_fire) begin
				skid_q <= step_result;
			end else begin
				main_q <= step_result;
			end
		end
	end

endmodule

// ----- rtl/wtg_checker.sv -----
// Port-level checks for windowed_trigger_gate_core, and the bind that
// attaches them. Depends on the top level's ports only.

module wtg_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready
);

	// Every accepted sample leaves a result pending in the next cycle.
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> out_valid)
		else $error("accepted sample produced no pending result");

	// Back-pressure on samples only happens with a result on display.
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("samples stalled with no result pending");

	// Ready drops only after a beat came in while the result side was stalled.
	a_ready_drop_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid && out_valid && !out_ready))
		else $error("samples.ready dropped without a stalled beat");

	// A result that is not taken stays on display.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result withdrawn before it was taken");

endmodule

bind windowed_trigger_gate_core wtg_checker u_wtg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (results.valid),
	.out_ready (results.ready)
);

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for windowed_trigger_gate_core: drives sample ticks and
// register writes, predicts every result beat. Needs wtg_pkg, wtg_stream_if, the core.

module tb;
	import wtg_pkg::*;

	localparam int WAIT_BITS  = 24;
	localparam int COUNT_BITS = 16;
	localparam int CFG_BITS   = (WAIT_BITS > COUNT_BITS) ? WAIT_BITS : COUNT_BITS;

	// Index 3 is not mapped to any register; a write there must change nothing.
	localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED = 2'd3;

	// Cycles without any beat on either channel before the run is declared hung.
	// The longest legal quiet stretch is the receiver hold-off plus a settle.
	localparam int QUIET_LIMIT  = 2000;
	// Extra cycles after the last result before a register write or the end.
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_OFF_CYCLES = 40;

	// Tracks the gate state and holds the results it expects, oldest first.
	class gate_tracker #(int WB = 24, int CB = 16);
		logic [WB-1:0] min_cfg;
		logic [WB-1:0] max_cfg;
		logic [CB-1:0] pass_cnt;
		logic          waiting;
		logic [WB-1:0] min_left;
		logic [WB-1:0] max_left;
		logic [CB-1:0] passes_left;
		wtg_result_t   expected_ticks[$];
		int            errors;
		int            checked;

		function new();
			min_cfg     = '0;
			max_cfg     = '0;
			pass_cnt    = CB'(1);
			passes_left = '0;
			errors      = 0;
			checked     = 0;
			reload();
		endfunction

		function void reload();
			min_left = min_cfg;
			max_left = max_cfg;
			waiting  = 1'b1;
		endfunction

		function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] value);
			case (idx)
				REG_MIN_WAIT:   min_cfg  = value[WB-1:0];
				REG_MAX_WAIT:   max_cfg  = value[WB-1:0];
				REG_PASS_COUNT: pass_cnt = value[CB-1:0];
				default:        return;
			endcase
			reload();
		endfunction

		function void note_tick(wtg_sample_t s);
			wtg_result_t r;
			if (waiting) begin
				if (min_left == 0) begin
					if (s.arm_trigger || (max_left == 0 && max_cfg != 0)) begin
						waiting     = 1'b0;
						passes_left = pass_cnt;
					end
				end else begin
					min_left = min_left - 1'b1;
				end
				if (max_cfg != 0 && max_left != 0)
					max_left = max_left - 1'b1;
			end
			r.trigger_out = 1'b0;
			if (!waiting && s.pass_trigger) begin
				r.trigger_out = 1'b1;
				passes_left   = passes_left - 1'b1;
				if (passes_left == 0)
					reload();
			end
			r.waiting = waiting;
			expected_ticks.push_back(r);
		endfunction

		function void check_tick(wtg_result_t got);
			wtg_result_t want;
			if (expected_ticks.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("tb: result beat %b arrived with nothing expected", got);
				return;
			end
			want = expected_ticks.pop_front();
			if (got.trigger_out !== want.trigger_out || got.waiting !== want.waiting) begin
				errors++;
				if (errors <= 10)
					$display("tb: result %0d: expected trig=%b wait=%b, got trig=%b wait=%b",
						checked, want.trigger_out, want.waiting,
						got.trigger_out, got.waiting);
			end
			checked++;
		endfunction

		function int pending();
			return expected_ticks.size();
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_wr_en;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0]       cfg_data;

	wtg_stream_if #(.payload_t(wtg_sample_t)) samples ();
	wtg_stream_if #(.payload_t(wtg_result_t)) results ();

	windowed_trigger_gate_core #(
		.WAIT_BITS  (WAIT_BITS),
		.COUNT_BITS (COUNT_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples),
		.results   (results),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	gate_tracker #(WAIT_BITS, COUNT_BITS) tracker;

	// Percentages of cycles in which the sender and the receiver idle.
	int src_idle_pct;
	int sink_idle_pct;
	// Set by the stimulus to ask the receiver for a long hold-off; the receiver
	// takes the request and counts the stretch down in its own process.
	int hold_request;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: drops ready at random, or for a whole hold-off stretch on request.
	initial begin
		int hold_left;
		hold_left     = 0;
		results.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				results.ready <= 1'b0;
				hold_left--;
			end else begin
				results.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	// Both channels are sampled at the edge, before the block's own updates
	// land, so a beat is seen exactly at the edge where it is accepted. The
	// result is checked ahead of the sample noted at the same edge, since a
	// result always belongs to an earlier sample.
	always @(posedge clk) begin
		if (results.valid && results.ready)
			tracker.check_tick(results.data);
		if (samples.valid && samples.ready)
			tracker.note_tick(samples.data);
	end

	// Watchdog: a hung handshake shows up as a long run of beat-free cycles.
	always @(posedge clk) begin
		if ((samples.valid && samples.ready) || (results.valid && results.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offers one sample tick, after a random gap, and returns once it is taken.
	// valid stays high across back-to-back beats and only drops for a gap or in settle.
	task automatic send_tick(input logic pass, input logic arm);
		wtg_sample_t beat;
		beat.pass_trigger = pass;
		beat.arm_trigger  = arm;
		while ($urandom_range(99) < src_idle_pct) begin
			samples.valid <= 1'b0;
			@(posedge clk);
		end
		samples.valid <= 1'b1;
		samples.data  <= beat;
		@(posedge clk);
		while (!samples.ready)
			@(posedge clk);
	endtask

	// Stops offering samples and waits until every expected result is in,
	// then waits SETTLE_CYCLES more for the result side to go quiet.
	task automatic settle();
		samples.valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register writes happen only with the block idle.
	task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
		input logic [CFG_BITS-1:0] value);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		tracker.write_reg(idx, value);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		int arm_pct;
		tracker       = new();
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_index     = REG_MIN_WAIT;
		cfg_data      = '0;
		samples.valid = 1'b0;
		samples.data  = '0;
		src_idle_pct  = 10;
		sink_idle_pct = 63;
		hold_request  = 0;
		quiet_cycles  = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: no minimum wait, no timeout, one pass per opening.
		// A pass trigger alone does nothing, an arm opens the gate, and an arm
		// together with a pass opens and passes in the same tick.
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b0);
		send_tick(1'b1, 1'b1);

		// Pass count written with junk above its 16 bits; only 3 must stick.
		write_register(REG_PASS_COUNT, 24'hFF0003);
		write_register(REG_MIN_WAIT, 24'd2);
		write_register(REG_MAX_WAIT, 24'd4);
		// Arms are ignored until the minimum wait has run down.
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b1);
		// Three consecutive pass triggers keep the output high, then close.
		send_tick(1'b1, 1'b0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b1, 1'b0);
		// Half way through the minimum wait, a write to the unmapped index
		// must not reload the counters.
		send_tick(1'b0, 1'b0);
		write_register(REG_UNMAPPED, {CFG_BITS{1'b1}});
		send_tick(1'b0, 1'b0);
		// No arm from here: the maximum wait runs out and opens the gate.
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0);

		// A zero pass count wraps, so the gate stays open far past any run
		// here; the next write closes it again.
		write_register(REG_MIN_WAIT, 24'd0);
		write_register(REG_PASS_COUNT, 24'd0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b0);
		send_tick(1'b1, 1'b0);

		// Largest values of every register.
		write_register(REG_MIN_WAIT, {CFG_BITS{1'b1}});
		send_tick(1'b1, 1'b1);
		write_register(REG_MAX_WAIT, {CFG_BITS{1'b1}});
		write_register(REG_PASS_COUNT, 24'h00FFFF);
		write_register(REG_MIN_WAIT, 24'd0);
		send_tick(1'b1, 1'b1);
		send_tick(1'b1, 1'b0);

		// Random part: three idling patterns, a few register settings in each.
		// Small waits and pass counts keep the gate cycling through its
		// phases; a zero pass count shows up now and then.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle_pct  = 10;
					sink_idle_pct = 63;
				end
				1: begin
					src_idle_pct  = 63;
					sink_idle_pct = 10;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
			endcase
			for (int setting = 0; setting < 4; setting++) begin
				write_register(REG_MIN_WAIT, CFG_BITS'($urandom_range(0, 6)));
				if ($urandom_range(2) == 0)
					write_register(REG_MAX_WAIT, '0);
				else
					write_register(REG_MAX_WAIT, CFG_BITS'($urandom_range(1, 10)));
				write_register(REG_PASS_COUNT, CFG_BITS'($urandom_range(0, 5)));
				arm_pct = $urandom_range(5, 40);
				for (int n = 0; n < 34; n++) begin
					// Once, with nothing idling, the receiver stalls long
					// enough for both result entries to fill and the sample
					// side to back up.
					if (phase == 2 && setting == 0 && n == 8)
						hold_request = HOLD_OFF_CYCLES;
					send_tick(1'($urandom_range(1)), ($urandom_range(99) < arm_pct));
				end
			end
		end

		settle();
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/wtg_pkg.sv
rtl/wtg_stream_if.sv
rtl/wtg_gate.sv
rtl/windowed_trigger_gate_core.sv
rtl/wtg_checker.sv
bench/tb.sv
